### design/dip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_pkg: shared widths for the dotted IPv4 address parser
// Field widths of the character and result channels.
// ----------------------------------------------------------------------------
package dip_pkg;

	localparam int CHAR_W = 8;
	localparam int ADDR_W = 32;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [ADDR_W-1:0] addr_t;

endpackage

### design/dip_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_in_if: character channel
// Valid/ready channel that carries one string character per item.
// ----------------------------------------------------------------------------
interface dip_in_if;
	import dip_pkg::*;

	logic  valid;
	logic  ready;
	char_t char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

### design/dip_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_out_if: result channel
// Valid/ready channel that carries one parsed address and its error flag.
// ----------------------------------------------------------------------------
interface dip_out_if;
	import dip_pkg::*;

	logic  valid;
	logic  ready;
	addr_t address;
	logic  parse_error;

	modport source (output valid, output address, output parse_error, input ready);
	modport sink (input valid, input address, input parse_error, output ready);
endinterface

### design/dotted_ipv4_address_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser: streaming dotted-quad address parser
// Parses NUL-terminated strings one character per item and emits the
// network-order address and an error flag when the NUL arrives.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                    | item
//  ---------+-----+----------------------------+--------------------------------
//  chars    | in  | char_code[7:0]             | one character, 0 ends a string
//  result   | out | address[31:0], parse_error | one per string, on its NUL
//
//  An accepted character lands in the input register; from there it
//  updates the parse state and, if it is a NUL, loads the result register.
//  One character per cycle, except while a NUL waits on a stalled result.
//  arst_n clears the parse state and both valid flags at once.
//  Only a NUL waiting on a full, stalled result register holds the input
//  register; all other characters keep flowing while a result waits.
//
module dotted_ipv4_address_parser (
	input logic        clk,
	input logic        arst_n,
	dip_in_if.sink     chars,
	dip_out_if.source  result
);
	import dip_pkg::*;

	// character codes
	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_0     = 8'h30;
	localparam char_t CH_9     = 8'h39;
	localparam char_t CH_DOT   = 8'h2e;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_LX    = 8'h78;
	localparam char_t CH_UX    = 8'h58;
	localparam char_t CH_LA    = 8'h61;
	localparam char_t CH_LF    = 8'h66;
	localparam char_t CH_UA    = 8'h41;
	localparam char_t CH_UF    = 8'h46;

	// range limits of the last part, by number of earlier parts
	localparam addr_t LIM_ONE   = 32'h00ff_ffff;
	localparam addr_t LIM_TWO   = 32'h0000_ffff;
	localparam addr_t LIM_THREE = 32'h0000_00ff;

	typedef enum logic [1:0] {
		PH_START,   // awaiting first digit of a part
		PH_ZERO,    // after a leading 0
		PH_DIGITS,  // inside the digits of a part
		PH_TRAIL    // after a trailing space, skip to NUL
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} base_t;

	// input register
	logic  valid_s1;
	char_t char_s1;

	// parse state
	phase_t        phase_q;
	base_t         base_q;
	addr_t         acc_q;
	logic [7:0]    part0_q;
	logic [15:0]   part1_q;
	logic [23:0]   part2_q;
	logic [1:0]    count_q;
	logic          failed_q;

	// result register
	logic  out_valid_q;
	addr_t out_addr_q;
	logic  out_err_q;

	// next state
	phase_t        phase_n;
	base_t         base_n;
	addr_t         acc_n;
	logic [7:0]    part0_n;
	logic [15:0]   part1_n;
	logic [23:0]   part2_n;
	logic [1:0]    count_n;
	logic          failed_n;
	logic          emit;
	addr_t         emit_addr;
	logic          emit_err;

	logic          is_nul;
	logic          advance;
	logic          is_dec;
	logic          is_lower_hex;
	logic          is_upper_hex;
	logic [3:0]    dig_val;
	base_t         eff_base;
	logic          prefix_x;
	addr_t         acc_scaled;
	addr_t         assembled;
	logic          range_bad;
	logic          bad;

	// Hold a NUL in the input register only while a result still waits.
	assign is_nul  = (char_s1 == CH_NUL);
	assign advance = valid_s1 && (!is_nul || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || advance;

	assign result.valid       = out_valid_q;
	assign result.address     = out_addr_q;
	assign result.parse_error = out_err_q;

	// Character classes and digit value.
	assign is_dec       = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	assign is_lower_hex = (char_s1 >= CH_LA) && (char_s1 <= CH_LF);
	assign is_upper_hex = (char_s1 >= CH_UA) && (char_s1 <= CH_UF);

	always_comb begin
		dig_val = 4'd0;
		if (is_dec) begin
			dig_val = 4'(char_s1 - CH_0);
		end else if (is_lower_hex) begin
			dig_val = 4'(char_s1 - CH_LA + 8'd10);
		end else if (is_upper_hex) begin
			dig_val = 4'(char_s1 - CH_UA + 8'd10);
		end
	end

	// After a leading 0 the next character either starts a hex prefix
	// or is parsed in octal.
	assign prefix_x = (phase_q == PH_ZERO) && ((char_s1 == CH_LX) || (char_s1 == CH_UX));
	assign eff_base = (phase_q == PH_ZERO) ? BASE_OCT : base_q;

	// Scale the accumulator by the base; wraps at 32 bits.
	always_comb begin
		unique case (eff_base)
			BASE_HEX: acc_scaled = {acc_q[27:0], 4'b0};
			BASE_OCT: acc_scaled = {acc_q[28:0], 3'b0};
			default:  acc_scaled = {acc_q[28:0], 3'b0} + {acc_q[30:0], 1'b0};
		endcase
	end

	// Place the earlier parts above the last one and range check it.
	always_comb begin
		assembled = acc_q | {part0_q, 24'b0} | {part1_q, 16'b0} | {part2_q, 8'b0};
		unique case (count_q)
			2'd0:    range_bad = 1'b0;
			2'd1:    range_bad = acc_q > LIM_ONE;
			2'd2:    range_bad = acc_q > LIM_TWO;
			default: range_bad = acc_q > LIM_THREE;
		endcase
	end

	// Parse step for the character in the input register.
	always_comb begin
		phase_n  = phase_q;
		base_n   = base_q;
		acc_n    = acc_q;
		part0_n  = part0_q;
		part1_n  = part1_q;
		part2_n  = part2_q;
		count_n  = count_q;
		failed_n = failed_q;
		emit     = 1'b0;

		if (failed_q || phase_q == PH_TRAIL) begin
			emit = is_nul;
		end else if (phase_q == PH_START) begin
			if (!is_dec) begin
				failed_n = 1'b1;
				emit     = is_nul;
			end else if (char_s1 == CH_0) begin
				acc_n   = '0;
				base_n  = BASE_OCT;
				phase_n = PH_ZERO;
			end else begin
				acc_n   = ADDR_W'(dig_val);
				base_n  = BASE_DEC;
				phase_n = PH_DIGITS;
			end
		end else if (prefix_x) begin
			base_n  = BASE_HEX;
			phase_n = PH_DIGITS;
		end else begin
			phase_n = PH_DIGITS;
			base_n  = eff_base;
			if (is_dec) begin
				acc_n = acc_scaled + ADDR_W'(dig_val);
			end else if (eff_base == BASE_HEX && (is_lower_hex || is_upper_hex)) begin
				acc_n = {acc_q[27:0], dig_val};
			end else if (char_s1 == CH_DOT) begin
				// fail on a fourth dot, else store this part and start the next
				if (count_q == 2'd3) begin
					failed_n = 1'b1;
				end else begin
					unique case (count_q)
						2'd0:    part0_n = acc_q[7:0];
						2'd1:    part1_n = acc_q[15:0];
						default: part2_n = acc_q[23:0];
					endcase
					count_n = count_q + 2'd1;
					acc_n   = '0;
					base_n  = BASE_DEC;
					phase_n = PH_START;
				end
			end else if (is_nul) begin
				emit = 1'b1;
			end else if (char_s1 == CH_SPACE) begin
				phase_n = PH_TRAIL;
			end else begin
				failed_n = 1'b1;
			end
		end
	end

	// Byte swap into network order; zero the address on error.
	assign bad       = failed_n || range_bad;
	assign emit_err  = bad;
	assign emit_addr = bad ? '0
		: {assembled[7:0], assembled[15:8], assembled[23:16], assembled[31:24]};

	// Input register: advance on accept, drop once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1 <= chars.char_code;
		end
	end

	// Parse state: advance per character, return to reset after a NUL.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			base_q   <= BASE_DEC;
			acc_q    <= '0;
			part0_q  <= '0;
			part1_q  <= '0;
			part2_q  <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
		end else if (advance) begin
			if (emit) begin
				phase_q  <= PH_START;
				base_q   <= BASE_DEC;
				acc_q    <= '0;
				part0_q  <= '0;
				part1_q  <= '0;
				part2_q  <= '0;
				count_q  <= '0;
				failed_q <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				base_q   <= base_n;
				acc_q    <= acc_n;
				part0_q  <= part0_n;
				part1_q  <= part1_n;
				part2_q  <= part2_n;
				count_q  <= count_n;
				failed_q <= failed_n;
			end
		end
	end

	// Result register: load on a processed NUL, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_addr_q <= emit_addr;
			out_err_q  <= emit_err;
		end
	end

endmodule

### design/dip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dip_checker: port-level checks for the address parser
// Watches the character and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module dip_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input dip_pkg::char_t       char_code,
	input logic                 out_valid,
	input logic                 out_ready,
	input dip_pkg::addr_t       address,
	input logic                 parse_error
);
	import dip_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(address) && $stable(parse_error))
		else $error("stalled result changed or dropped");

	// a failed string reports address zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && parse_error |-> address == '0)
		else $error("error result with nonzero address");

	// an empty result register never blocks the character channel
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a fresh result follows an accepted NUL that passed the input register
	a_nul_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && char_code == '0, 2))
		else $error("result without a NUL two cycles earlier");

endmodule

bind dotted_ipv4_address_parser dip_checker u_dip_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (chars.valid),
	.in_ready    (chars.ready),
	.char_code   (chars.char_code),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.address     (result.address),
	.parse_error (result.parse_error)
);

### dv/dotted_ipv4_address_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser_tb: self-checking bench for the address parser
// Streams NUL-terminated strings into the parser and checks every result
// against a cycle-free parser model kept in the bench. The bench starts with
// a short list of hand-picked strings, then random well-formed addresses
// with noise and junk under several idle and stall patterns, with one long
// result hold-off.
// ----------------------------------------------------------------------------
module dotted_ipv4_address_parser_tb;
	import dip_pkg::*;

	// Character codes the parser cares about
	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_DOT    = 8'h2E;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_EIGHT  = 8'h38;
	localparam char_t CH_NINE   = 8'h39;
	localparam char_t CH_UP_A   = 8'h41;
	localparam char_t CH_UP_F   = 8'h46;
	localparam char_t CH_UP_X   = 8'h58;
	localparam char_t CH_LOW_A  = 8'h61;
	localparam char_t CH_LOW_F  = 8'h66;
	localparam char_t CH_LOW_X  = 8'h78;
	localparam char_t CH_TOP    = 8'hFF;
	localparam char_t CASE_GAP  = 8'h20;

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_CHARS     = 300;
	localparam int DRAIN_LIMIT     = 5000;

	// Values at the edges of the last-part range checks
	localparam logic [31:0] EDGE_VALUES [8] = '{
		32'h0, 32'hFF, 32'h100, 32'hFFFF, 32'h1_0000, 32'hFF_FFFF, 32'h100_0000, 32'hFFFF_FFFF
	};

	typedef enum logic [2:0] {
		AT_PART_START,
		AFTER_LEAD_ZERO,
		IN_DIGITS,
		AFTER_SPACE
	} parse_phase_e;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_OCT,
		BASE_HEX
	} num_base_e;

	typedef struct packed {
		addr_t address;
		logic  parse_error;
	} parse_result_t;

	logic clk;
	logic arst_n;

	dip_in_if  chars ();
	dip_out_if result ();

	dotted_ipv4_address_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// Parser model: state of the string being parsed
	// ------------------------------------------------------------------
	parse_phase_e ps_phase;
	num_base_e    ps_base;
	logic [31:0]  ps_acc;
	logic [31:0]  ps_parts [3];
	logic [1:0]   ps_count;
	bit           ps_failed;

	// Items waiting for the driver, results waiting for the monitor
	char_t         pending_chars [$];
	parse_result_t expected_results [$];

	bit char_fire;
	bit mismatch_seen;
	bit hold_go;
	bit hold_active;
	int sender_idle_pct;
	int receiver_stall_pct;

	function automatic void clear_parser();
		ps_phase  = AT_PART_START;
		ps_base   = BASE_DEC;
		ps_acc    = '0;
		ps_parts  = '{default: '0};
		ps_count  = '0;
		ps_failed = 1'b0;
	endfunction

	function automatic bit is_digit(input char_t c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Close the string on its NUL: merge the parts, range check the last one,
	// byte swap into network order, then start over for the next string.
	function automatic parse_result_t close_string();
		parse_result_t r;
		logic [31:0]   v;
		bit            bad;
		bad = ps_failed;
		v   = ps_acc;
		if (!bad) begin
			case (ps_count)
				2'd0: ;
				2'd1: begin
					bad = v > 32'hFF_FFFF;
					v   = v | (ps_parts[0] << 24);
				end
				2'd2: begin
					bad = v > 32'hFFFF;
					v   = v | (ps_parts[0] << 24) | (ps_parts[1] << 16);
				end
				default: begin
					bad = v > 32'hFF;
					v   = v | (ps_parts[0] << 24) | (ps_parts[1] << 16) | (ps_parts[2] << 8);
				end
			endcase
		end
		r.parse_error = bad;
		r.address     = bad ? '0 : {v[7:0], v[15:8], v[23:16], v[31:24]};
		clear_parser();
		return r;
	endfunction

	// Advance the model by one character; return 1 when it yields a result.
	function automatic bit parse_char(input char_t c, output parse_result_t predicted);
		logic [31:0] radix;
		predicted = '0;
		if (ps_failed || ps_phase == AFTER_SPACE) begin
			if (c == CH_NUL) begin
				predicted = close_string();
				return 1'b1;
			end
			return 1'b0;
		end
		if (ps_phase == AT_PART_START) begin
			if (!is_digit(c)) begin
				ps_failed = 1'b1;
				if (c == CH_NUL) begin
					predicted = close_string();
					return 1'b1;
				end
				return 1'b0;
			end
			ps_acc = 32'(c - CH_ZERO);
			if (c == CH_ZERO) begin
				ps_base  = BASE_OCT;
				ps_phase = AFTER_LEAD_ZERO;
			end else begin
				ps_base  = BASE_DEC;
				ps_phase = IN_DIGITS;
			end
			return 1'b0;
		end
		if (ps_phase == AFTER_LEAD_ZERO) begin
			ps_phase = IN_DIGITS;
			if (c == CH_LOW_X || c == CH_UP_X) begin
				ps_base = BASE_HEX;
				return 1'b0;
			end
			ps_base = BASE_OCT;
		end
		// Inside the digits of a part; octal still takes 8 and 9
		if (is_digit(c)) begin
			radix  = (ps_base == BASE_HEX) ? 32'd16 : (ps_base == BASE_OCT) ? 32'd8 : 32'd10;
			ps_acc = ps_acc * radix + 32'(c - CH_ZERO);
		end else if (ps_base == BASE_HEX && c >= CH_LOW_A && c <= CH_LOW_F) begin
			ps_acc = {ps_acc[27:0], 4'(c - CH_LOW_A + 8'd10)};
		end else if (ps_base == BASE_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
			ps_acc = {ps_acc[27:0], 4'(c - CH_UP_A + 8'd10)};
		end else if (c == CH_DOT) begin
			if (ps_count == 2'd3) begin
				ps_failed = 1'b1;
			end else begin
				ps_parts[ps_count] = ps_acc;
				ps_count++;
				ps_acc   = '0;
				ps_base  = BASE_DEC;
				ps_phase = AT_PART_START;
			end
		end else if (c == CH_NUL) begin
			predicted = close_string();
			return 1'b1;
		end else if (c == CH_SPACE) begin
			ps_phase = AFTER_SPACE;
		end else begin
			ps_failed = 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// String generation
	// ------------------------------------------------------------------

	// One part: decimal, octal (sometimes with 8 or 9) or hex in mixed case.
	// Values lean on the range-check edges; a few get extra digits to wrap.
	function automatic string number_text();
		logic [31:0] val;
		string       s;
		int          kind;
		case ($urandom_range(7))
			0, 1:    val = EDGE_VALUES[$urandom_range(7)];
			2:       val = $urandom();
			default: val = $urandom_range(255);
		endcase
		kind = $urandom_range(19);
		if (kind == 0) begin
			return "0";
		end else if (kind == 1) begin
			return "0x";
		end else if (kind < 11) begin
			s = $sformatf("%0d", val);
		end else if (kind < 15) begin
			s = $sformatf("0%0o", val);
			if ($urandom_range(3) == 0)
				s.putc($urandom_range(s.len() - 1, 1), $urandom_range(1) ? CH_EIGHT : CH_NINE);
		end else begin
			s = $sformatf("%0h", val);
			for (int i = 0; i < s.len(); i++)
				if (s.getc(i) >= CH_LOW_A && $urandom_range(1))
					s.putc(i, s.getc(i) - CASE_GAP);
			if ($urandom_range(1))
				s = {"0X", s};
			else
				s = {"0x", s};
		end
		if ($urandom_range(15) == 0)
			s = {s, $sformatf("%0d", $urandom_range(99999))};
		return s;
	endfunction

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pending_chars.push_back(s.getc(i));
	endtask

	// A well-formed address, now and then with a fifth part, a trailing dot,
	// a stray byte, or a space followed by junk.
	task automatic queue_address();
		int    parts;
		string s;
		parts = $urandom_range(4, 1);
		if ($urandom_range(15) == 0)
			parts = 5;
		s = number_text();
		for (int i = 1; i < parts; i++)
			s = {s, ".", number_text()};
		case ($urandom_range(11))
			0: s = {s, "."};
			1: s.putc($urandom_range(s.len() - 1), 8'($urandom_range(255, 1)));
			default: ;
		endcase
		push_text(s);
		if ($urandom_range(5) == 0) begin
			pending_chars.push_back(CH_SPACE);
			repeat ($urandom_range(4))
				pending_chars.push_back(char_t'($urandom_range(255, 1)));
		end
		pending_chars.push_back(CH_NUL);
	endtask

	// Random bytes, empty strings among them
	task automatic queue_junk();
		repeat ($urandom_range(6))
			pending_chars.push_back(char_t'($urandom_range(255, 1)));
		pending_chars.push_back(CH_NUL);
	endtask

	task automatic queue_random(input int char_budget);
		int added;
		int before_size;
		added = 0;
		while (added < char_budget) begin
			before_size = pending_chars.size();
			if ($urandom_range(7) == 0)
				queue_junk();
			else
				queue_address();
			added += pending_chars.size() - before_size;
		end
	endtask

	task automatic wait_drained();
		while (pending_chars.size() != 0 || chars.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: present the next item at the falling edge once the last one
	// was taken; idle at random when the sender idle rate asks for it.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : char_driver
		logic  next_valid;
		char_t next_char;
		next_valid = chars.valid;
		next_char  = chars.char_code;
		if (!arst_n) begin
			next_valid = 1'b0;
			next_char  = CH_NUL;
		end else if (!chars.valid || char_fire) begin
			next_valid = 1'b0;
			if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_valid = 1'b1;
				next_char  = pending_chars.pop_front();
			end
		end
		chars.valid     <= next_valid;
		chars.char_code <= next_char;
	end

	// Long result hold-off, counted in clock cycles once requested
	initial begin : hold_off
		hold_active = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_active = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		hold_active = 1'b0;
	end

	// Result ready: low through reset and the hold-off, else stall at random
	always @(negedge clk) begin : result_ready_driver
		if (!arst_n || hold_active) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: feed each accepted character to the model and check each
	// accepted result against the oldest prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		parse_result_t predicted;
		parse_result_t oldest;
		char_fire = 1'b0;
		if (arst_n !== 1'b1) begin
			clear_parser();
		end else begin
			if (chars.valid && chars.ready) begin
				char_fire = 1'b1;
				if (parse_char(chars.char_code, predicted))
					expected_results.push_back(predicted);
			end
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: address %h parse_error %b",
						result.address, result.parse_error);
					mismatch_seen = 1'b1;
				end else begin
					oldest = expected_results.pop_front();
					if (result.address !== oldest.address) begin
						$error("address: expected %h, got %h", oldest.address, result.address);
						mismatch_seen = 1'b1;
					end
					if (result.parse_error !== oldest.parse_error) begin
						$error("parse_error: expected %b, got %b",
							oldest.parse_error, result.parse_error);
						mismatch_seen = 1'b1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		int spins;
		bit lost;
		hold_go            = 1'b0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings, back to back
		pending_chars.push_back(CH_NUL);            // empty string
		push_text("0.0x.09");                       // bare prefixes, 9 in octal
		pending_chars.push_back(CH_NUL);
		push_text("1.2.3.4.5");                     // fifth part
		pending_chars.push_back(CH_NUL);
		pending_chars.push_back(CH_TOP);            // high code at part start
		pending_chars.push_back(CH_NUL);
		push_text("1.2.256");                       // last part above 255, still in range
		pending_chars.push_back(CH_NUL);
		push_text("0XFfffffffff");                  // wraps past 32 bits
		pending_chars.push_back(CH_NUL);
		push_text("7 z");                           // junk after a space
		pending_chars.push_back(CH_NUL);
		wait_drained();

		// No idling, with a long result hold-off so the parser backs up
		@(posedge clk);
		hold_go = 1'b1;
		queue_random(PHASE_CHARS);
		wait_drained();

		sender_idle_pct = 81;
		queue_random(PHASE_CHARS);
		wait_drained();

		sender_idle_pct    = 0;
		receiver_stall_pct = 81;
		queue_random(PHASE_CHARS);
		wait_drained();

		sender_idle_pct    = 17;
		receiver_stall_pct = 17;
		queue_random(PHASE_CHARS);

		// Let the last items drain, then give stray results time to show
		while (pending_chars.size() != 0 || chars.valid)
			@(posedge clk);
		spins = 0;
		while (expected_results.size() != 0 && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		lost = (expected_results.size() != 0);
		if (lost)
			$error("%0d expected results never arrived", expected_results.size());
		repeat (10) @(posedge clk);
		if (!mismatch_seen && !lost) begin
			$display("dotted_ipv4_address_parser_tb passed");
		end else begin
			$display("dotted_ipv4_address_parser_tb failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin : watchdog
		#5_000_000;
		$display("dotted_ipv4_address_parser_tb failed");
		$finish;
	end

endmodule

### files.f
design/dip_pkg.sv
design/dip_in_if.sv
design/dip_out_if.sv
design/dotted_ipv4_address_parser.sv
design/dip_checker.sv
dv/dotted_ipv4_address_parser_tb.sv
